FILE: src/rcrc_pkg.sv
package rcrc_pkg;
  localparam int ROWS = 1024;
  localparam int COLS = 1024;
  localparam int RLW = $clog2(ROWS);
  localparam int CLW = $clog2(COLS);
  localparam int TLW = (RLW > CLW) ? RLW : CLW;
  localparam int TSW = TLW + 1;
  localparam int CRDW = 11;
  localparam int CNTW = 21;
  localparam int REQ_TOGGLE = 0;
  localparam int REQ_QUERY = 1;
  localparam int REG_ROW_COUNT = 0;
  localparam int REG_COL_COUNT = 1;
endpackage

FILE: src/rcrc_ram.sv
module rcrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/rcrc_tree.sv
module rcrc_tree import rcrc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           mode_sum,
  input  logic [TLW-1:0] lo,
  input  logic [TLW-1:0] hi,
  output logic           busy,
  output logic           done,
  output logic [TSW-1:0] sum
);
  localparam int AW = TLW + 1;
  localparam int SIZE = 1 << TLW;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR = 3'd1;
  localparam logic [2:0] S_FRD = 3'd2;
  localparam logic [2:0] S_FWR = 3'd3;
  localparam logic [2:0] S_SRD = 3'd4;
  localparam logic [2:0] S_SWT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [AW-1:0] p, raddr, waddr;
  logic [AW:0] l, r;
  logic [TSW-1:0] wdata, rdata, acc;
  logic [1:0] phase;
  logic we, take_l, take_r;
  logic [AW-1:0] pick;

  rcrc_ram #(.WIDTH(TSW), .DEPTH(2 * SIZE)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // A flip reads the leaf then each sibling, rewriting the parent from the
  // sum held in acc. A range sum reads the boundary nodes one at a time into acc.
  assign take_l = l[0];
  assign take_r = r[0];

  always_comb begin
    we = 1'b0;
    waddr = p;
    wdata = acc;
    raddr = p;
    pick = take_l ? l[AW-1:0] : AW'(r - (AW+1)'(1));
    unique case (state)
      S_CLR: begin
        we = 1'b1;
        wdata = '0;
      end
      S_FRD: raddr = (phase == 2'd0) ? p : (p ^ AW'(1));
      S_FWR: begin
        we = 1'b1;
        if (phase == 2'd1) begin
          wdata = rdata ^ TSW'(1);
        end else begin
          waddr = p >> 1;
          wdata = acc + rdata;
        end
      end
      S_SRD: raddr = pick;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      p <= '0;
      phase <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            acc <= '0;
            phase <= '0;
            if (mode_sum) begin
              l <= (AW+1)'(lo) + (AW+1)'(SIZE);
              r <= (AW+1)'(hi) + (AW+1)'(SIZE) + (AW+1)'(1);
              state <= S_SRD;
            end else begin
              p <= AW'(lo) + AW'(SIZE);
              state <= S_FRD;
            end
          end
        end
        S_CLR: begin
          p <= p + AW'(1);
          if (p == AW'(2 * SIZE - 1)) state <= S_IDLE;
        end
        S_FRD: begin
          state <= S_FWR;
          if (phase == 2'd0) phase <= 2'd1;
        end
        S_FWR: begin
          if (phase == 2'd1) begin
            acc <= rdata ^ TSW'(1);
            phase <= 2'd2;
          end else begin
            acc <= acc + rdata;
          end
          if (phase == 2'd1) begin
            state <= S_FRD;
          end else begin
            if (p[AW-1:1] == (AW-1)'(1)) begin
              state <= S_DONE;
            end else begin
              p <= p >> 1;
              state <= S_FRD;
            end
          end
        end
        S_SRD: begin
          if (l >= r) begin
            sum <= acc;
            state <= S_DONE;
          end else if (take_l || take_r) begin
            state <= S_SWT;
          end else begin
            l <= l >> 1;
            r <= r >> 1;
          end
        end
        S_SWT: begin
          acc <= acc + rdata;
          if (take_l) begin
            l <= l + (AW+1)'(1);
          end else begin
            r <= r - (AW+1)'(1);
          end
          state <= S_SRD;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
endmodule

FILE: src/row_col_toggle_rect_count.sv
// Keeps a parity bit per row and per column in two sum trees held in block
// RAM and answers toggles and rectangle odd-cell counts, one result per
// request. The walk of the trees sets the time, one memory access per
// cycle, with both trees walking in parallel; the time a query takes
// depends on how many tree nodes the range covers. A request out of range
// is answered in the next cycle. The next request is taken in the cycle
// after the result has been accepted. After reset the trees clear every
// node before the first request is taken; configuration writes are taken
// at any time.
module row_col_toggle_rect_count import rcrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // row_a, col_a, row_b, col_b
  input  logic [47:0] s_tdata,
  // req_type
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cell_count
  output logic [23:0] m_tdata,
  // bad_range
  output logic        m_tuser
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_MUL = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state;
  logic [10:0] row_count, col_count, rows, cols;
  logic req_type;
  logic [10:0] ra, ca, rb, cb;
  logic bad, acc_in, r_busy, c_busy, r_done, c_done, r_seen, c_seen, go;
  logic [TSW-1:0] r_sum;
  logic [TSW-1:0] c_sum;
  logic [10:0] h, w;
  logic [CNTW-1:0] p1, p2;
  logic [CNTW-1:0] cell_count;
  logic bad_range;

  assign req_type = s_tuser;
  assign ra = s_tdata[10:0];
  assign ca = s_tdata[21:11];
  assign rb = s_tdata[32:22];
  assign cb = s_tdata[43:33];
  assign rows = (row_count > 11'(ROWS)) ? 11'(ROWS) : row_count;
  assign cols = (col_count > 11'(COLS)) ? 11'(COLS) : col_count;

  always_comb begin
    if (req_type == 1'(REQ_TOGGLE)) begin
      bad = ra == 0 || ra > rows || ca == 0 || ca > cols;
    end else begin
      bad = ra == 0 || rb > rows || ra > rb || ca == 0 || cb > cols || ca > cb;
    end
  end

  assign s_tready = (state == S_IDLE) && !r_busy && !c_busy;
  assign acc_in = s_tvalid && s_tready;
  assign go = acc_in && !bad;

  rcrc_tree u_row (
    .clk(clk), .rst(rst), .start(go), .mode_sum(req_type),
    .lo(TLW'(ra - 11'd1)), .hi(TLW'(rb - 11'd1)),
    .busy(r_busy), .done(r_done), .sum(r_sum)
  );
  rcrc_tree u_col (
    .clk(clk), .rst(rst), .start(go), .mode_sum(req_type),
    .lo(TLW'(ca - 11'd1)), .hi(TLW'(cb - 11'd1)),
    .busy(c_busy), .done(c_done), .sum(c_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row_count <= 11'd1024;
      col_count <= 11'd1024;
      m_tvalid <= 1'b0;
      r_seen <= 1'b0;
      c_seen <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(REG_ROW_COUNT)) row_count <= cfg_data;
        else col_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (acc_in) begin
            cell_count <= '0;
            bad_range <= bad;
            h <= (req_type == 1'(REQ_TOGGLE)) ? 11'd0 : rb - ra + 11'd1;
            w <= cb - ca + 11'd1;
            state <= bad ? S_OUT : S_WAIT;
            r_seen <= 1'b0;
            c_seen <= 1'b0;
            if (bad) m_tvalid <= 1'b1;
          end
        end
        S_WAIT: begin
          if (r_done) r_seen <= 1'b1;
          if (c_done) c_seen <= 1'b1;
          if ((r_seen || r_done) && (c_seen || c_done)) begin
            if (h == '0) begin
              m_tvalid <= 1'b1;
              state <= S_OUT;
            end else begin
              p1 <= CNTW'(r_sum) * CNTW'(w - 11'(c_sum));
              p2 <= CNTW'(c_sum) * CNTW'(h - 11'(r_sum));
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          cell_count <= p1 + p2;
          m_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {3'b000, cell_count};
  assign m_tuser = bad_range;

  a_out_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == S_OUT) else $error("result shown outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (r_busy || c_busy) |-> !s_tready) else $error("request taken during tree walk");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
endmodule
